@@ hdl/mlpq_pkg.sv @@
// Shared types and constants for the multilevel priority queue.
package mlpq_pkg;

   // Default sizing
   localparam int LEVELS_DEF      = 8;
   localparam int LEVEL_DEPTH_DEF = 16;

   // Port field widths
   localparam int CMD_W    = 2;
   localparam int TASK_W   = 16;
   localparam int PRIO_W   = 4;
   localparam int STATUS_W = 2;
   localparam int LCOUNT_W = 5;
   localparam int TCOUNT_W = 8;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // apply the latched request to the queue state
   } ctl_type;

endpackage

@@ hdl/multilevel_priority_queue.sv @@
// Top level of the multilevel priority queue.
// A request is applied in the execute state and answered in the response state.
// A new request can be taken while a response is shown; busy is high only in the
// execute state, so no request is taken while the last one is being applied.
// Synchronous reset empties every level at once; memory contents need no clearing.
// The response lasts one cycle and cannot be stalled by the receiver.
module multilevel_priority_queue
   import mlpq_pkg::*;
#(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [TASK_W-1:0]   req_task_id,
   input  logic [PRIO_W-1:0]   req_priority_req,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TASK_W-1:0]   rsp_out_task_id,
   output logic [PRIO_W-1:0]   rsp_out_priority,
   output logic [LCOUNT_W-1:0] rsp_level_count,
   output logic [TCOUNT_W-1:0] rsp_total_count,
   output logic                rsp_all_empty
);

   ctl_type ctl;

   // Sequencer
   mlpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl)
   );

   // Queue storage and response formation
   mlpq_datapath #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_command),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_status       (rsp_status),
      .rsp_out_task_id  (rsp_out_task_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_level_count  (rsp_level_count),
      .rsp_total_count  (rsp_total_count),
      .rsp_all_empty    (rsp_all_empty)
   );

endmodule

@@ hdl/mlpq_ctrl.sv @@
// Controller state machine: sequences capture, execute and response.
module mlpq_ctrl
   import mlpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_strobe,
   output ctl_type ctl
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // a new request may be taken while the response is shown
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctl.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            ctl.execute = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe  = 1'b1;
            ctl.capture = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/mlpq_datapath.sv @@
// Datapath: per-level FIFO pointers and counts, task memory, result registers.
module mlpq_datapath
   import mlpq_pkg::*;
#(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [TASK_W-1:0]   req_task_id,
   input  logic [PRIO_W-1:0]   req_priority_req,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TASK_W-1:0]   rsp_out_task_id,
   output logic [PRIO_W-1:0]   rsp_out_priority,
   output logic [LCOUNT_W-1:0] rsp_level_count,
   output logic [TCOUNT_W-1:0] rsp_total_count,
   output logic                rsp_all_empty
);

   localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PW    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CW    = $clog2(LEVEL_DEPTH + 1);
   localparam int SLOTS = LEVELS * LEVEL_DEPTH;
   localparam int AW    = $clog2(SLOTS);
   localparam int TW    = $clog2(SLOTS + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(LEVEL_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(LEVEL_DEPTH);

   // Latched request
   logic [CMD_W-1:0]  cmd_ff;
   logic [TASK_W-1:0] task_ff;
   logic [PRIO_W-1:0] prio_ff;

   // Queue state
   logic [PW-1:0] head_ff [LEVELS];
   logic [PW-1:0] head_in [LEVELS];
   logic [PW-1:0] tail_ff [LEVELS];
   logic [PW-1:0] tail_in [LEVELS];
   logic [CW-1:0] cnt_ff  [LEVELS];
   logic [CW-1:0] cnt_in  [LEVELS];
   logic [TW-1:0] total_ff, total_in;

   // Task memory and result registers
   logic [TASK_W-1:0]   mem [SLOTS];
   logic [TASK_W-1:0]   rd_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                hit_ff;
   logic [LW-1:0]       top_ff;

   // Decode
   logic              prio_ok;
   logic [LW-1:0]     lvl_req;
   logic [LEVELS-1:0] nonempty;
   logic              any_busy;
   logic [LW-1:0]     top;
   logic              full_req;
   logic              is_push, is_read;
   logic              do_push, do_read, do_pop;
   logic [AW-1:0]     mem_addr;
   logic [31:0]       addr_wide;
   logic [31:0]       lcount_wide;
   logic [31:0]       total_wide;
   logic [31:0]       prio_wide;

   // Request capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_command;
         task_ff <= req_task_id;
         prio_ff <= req_priority_req;
      end
   end

   // Range check and level index of the named priority
   assign prio_ok = (prio_ff != '0) && (32'(prio_ff) <= 32'(LEVELS));
   assign lvl_req = LW'(32'(prio_ff) - 32'd1);

   // Highest non-empty level
   always_comb begin
      top = '0;
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (cnt_ff[i] != '0);
         if (nonempty[i]) top = LW'(i);
      end
   end
   assign any_busy = |nonempty;

   assign full_req = (cnt_ff[lvl_req] == CNT_FULL);
   assign is_push  = (cmd_ff == CMD_PUSH);
   assign is_read  = (cmd_ff == CMD_POP) || (cmd_ff == CMD_PEEK);
   assign do_push  = ctl.execute && prio_ok && is_push && !full_req;
   assign do_read  = ctl.execute && prio_ok && is_read && any_busy;
   assign do_pop   = do_read && (cmd_ff == CMD_POP);

   // Status of this request
   always_comb begin
      status_in = ST_OK;
      if (!prio_ok) begin
         status_in = ST_RANGE;
      end else if (is_push && full_req) begin
         status_in = ST_FULL;
      end else if (is_read && !any_busy) begin
         status_in = ST_EMPTY;
      end
   end

   // Memory slot: tail of the named level on push, head of the top level on read
   always_comb begin
      if (is_push) begin
         addr_wide = 32'(lvl_req) * 32'(LEVEL_DEPTH) + 32'(tail_ff[lvl_req]);
      end else begin
         addr_wide = 32'(top) * 32'(LEVEL_DEPTH) + 32'(head_ff[top]);
      end
   end
   assign mem_addr = addr_wide[AW-1:0];

   // Pointer and count updates
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      if (do_push) begin
         tail_in[lvl_req] = (tail_ff[lvl_req] == PTR_LAST) ? '0 : tail_ff[lvl_req] + 1'b1;
         cnt_in[lvl_req]  = cnt_ff[lvl_req] + 1'b1;
         total_in         = total_ff + 1'b1;
      end
      if (do_pop) begin
         head_in[top] = (head_ff[top] == PTR_LAST) ? '0 : head_ff[top] + 1'b1;
         cnt_in[top]  = cnt_ff[top] - 1'b1;
         total_in     = total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         total_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
      end
   end

   // Single-port task memory with registered read
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[mem_addr] <= task_ff;
      end
      if (do_read) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         status_ff <= status_in;
         hit_ff    <= do_read;
         top_ff    <= top;
      end
   end

   // Response fields; counts already reflect this request
   assign prio_wide   = 32'(top_ff) + 32'd1;
   assign lcount_wide = prio_ok ? 32'(cnt_ff[lvl_req]) : 32'd0;
   assign total_wide  = 32'(total_ff);

   assign rsp_status       = status_ff;
   assign rsp_out_task_id  = hit_ff ? rd_ff : '0;
   assign rsp_out_priority = hit_ff ? prio_wide[PRIO_W-1:0] : '0;
   assign rsp_level_count  = lcount_wide[LCOUNT_W-1:0];
   assign rsp_total_count  = total_wide[TCOUNT_W-1:0];
   assign rsp_all_empty    = (total_ff == '0);

endmodule

@@ hdl/mlpq_checker.sv @@
// Port-level checker for the multilevel priority queue, bound to the top level.
module mlpq_checker
   import mlpq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [TASK_W-1:0]   rsp_out_task_id,
   input logic [PRIO_W-1:0]   rsp_out_priority
);

   // An accepted request is executed in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // Every accepted request gets its response after the execute state
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing two cycles after request");

   // Responses never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // A rejected request returns no task
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |->
         (rsp_out_task_id == '0) && (rsp_out_priority == '0))
      else $error("rejected request returned a task");

endmodule

bind multilevel_priority_queue mlpq_checker u_mlpq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_out_task_id (rsp_out_task_id),
   .rsp_out_priority(rsp_out_priority)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the multilevel priority queue: shadow queue model and stimulus.
import mlpq_pkg::*;

// One response as the block reports it
typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [TASK_W-1:0]   task_id;
   logic [PRIO_W-1:0]   priority_lvl;
   logic [LCOUNT_W-1:0] level_count;
   logic [TCOUNT_W-1:0] total_count;
   logic                all_empty;
} queue_response_type;

// Shadow copy of the queue state plus the responses still owed by the block
class priority_queue_shadow;
   logic [TASK_W-1:0]                      task_mem [LEVELS_DEF][LEVEL_DEPTH_DEF];
   logic [$clog2(LEVEL_DEPTH_DEF)-1:0]     head_ptr [LEVELS_DEF];
   logic [$clog2(LEVEL_DEPTH_DEF)-1:0]     tail_ptr [LEVELS_DEF];
   logic [LCOUNT_W-1:0]                    level_fill [LEVELS_DEF];
   logic [TCOUNT_W-1:0]                    total_fill;
   queue_response_type                     owed_responses [$];
   int unsigned                            failures;

   function new();
      for (int i = 0; i < LEVELS_DEF; i++) begin
         head_ptr[i]   = '0;
         tail_ptr[i]   = '0;
         level_fill[i] = '0;
      end
      total_fill = '0;
      failures   = 0;
   endfunction

   function int pending();
      return owed_responses.size();
   endfunction

   // Apply an accepted request to the shadow state and queue its response
   function void note_request(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                              logic [PRIO_W-1:0] prio);
      queue_response_type resp;
      bit                 prio_ok;
      int                 lvl;
      int                 top;
      resp    = '0;
      prio_ok = (prio >= 1) && (prio <= LEVELS_DEF);
      lvl     = int'(prio) - 1;
      top     = -1;
      for (int i = LEVELS_DEF - 1; i >= 0; i--) begin
         if (top < 0 && level_fill[i] != 0) top = i;
      end

      if (!prio_ok) begin
         resp.status = ST_RANGE;
      end else if (cmd == CMD_PUSH) begin
         if (level_fill[lvl] >= LEVEL_DEPTH_DEF) begin
            resp.status = ST_FULL;
         end else begin
            task_mem[lvl][tail_ptr[lvl]] = tid;
            tail_ptr[lvl] = (tail_ptr[lvl] == LEVEL_DEPTH_DEF - 1) ? '0 : tail_ptr[lvl] + 1'b1;
            level_fill[lvl]++;
            total_fill++;
         end
      end else if (cmd == CMD_POP || cmd == CMD_PEEK) begin
         if (top < 0) begin
            resp.status = ST_EMPTY;
         end else begin
            resp.task_id      = task_mem[top][head_ptr[top]];
            resp.priority_lvl = PRIO_W'(top + 1);
            if (cmd == CMD_POP) begin
               head_ptr[top] = (head_ptr[top] == LEVEL_DEPTH_DEF - 1) ? '0 :
                               head_ptr[top] + 1'b1;
               level_fill[top]--;
               total_fill--;
            end
         end
      end
      // unused command code: nothing changes, status stays ok

      if (prio_ok) resp.level_count = level_fill[lvl];
      resp.total_count = total_fill;
      resp.all_empty   = (total_fill == 0);
      owed_responses.push_back(resp);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // Match a strobed response against the oldest owed one
   function void check_response(queue_response_type got);
      queue_response_type want;
      if (owed_responses.size() == 0) begin
         $error("response with none outstanding: status %0d", got.status);
         failures++;
         return;
      end
      want = owed_responses.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_task_id", want.task_id, got.task_id);
      compare_field("out_priority", want.priority_lvl, got.priority_lvl);
      compare_field("level_count", want.level_count, got.level_count);
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("all_empty", want.all_empty, got.all_empty);
   endfunction
endclass

module testbench;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 10;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [TASK_W-1:0]   req_task_id;
   logic [PRIO_W-1:0]   req_priority_req;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [TASK_W-1:0]   rsp_out_task_id;
   logic [PRIO_W-1:0]   rsp_out_priority;
   logic [LCOUNT_W-1:0] rsp_level_count;
   logic [TCOUNT_W-1:0] rsp_total_count;
   logic                rsp_all_empty;

   priority_queue_shadow shadow;
   int unsigned          cycle_count = 0;
   bit                   idling_on;

   multilevel_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_task_id  (rsp_out_task_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_level_count  (rsp_level_count),
      .rsp_total_count  (rsp_total_count),
      .rsp_all_empty    (rsp_all_empty)
   );

   always #5ns clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Monitor: check strobed responses, then record accepted requests
   always @(posedge clock) begin
      if (!reset && shadow != null) begin
         if (rsp_strobe)
            shadow.check_response('{rsp_status, rsp_out_task_id, rsp_out_priority,
                                    rsp_level_count, rsp_total_count, rsp_all_empty});
         if (start && !busy)
            shadow.note_request(req_command, req_task_id, req_priority_req);
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] tid,
                               input logic [PRIO_W-1:0] prio);
      start            <= 1'b1;
      req_command      <= cmd;
      req_task_id      <= tid;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      if (start) start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] tid,
                        input logic [PRIO_W-1:0] prio);
      if (idling_on && $urandom_range(0, 99) < 6) hold_off($urandom_range(1, 4));
      send_request(cmd, tid, prio);
   endtask

   // Stop sending until every owed response has come back
   task automatic drain_responses();
      if (start) start <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   initial begin
      int                items_sent;
      int                phase_kind;
      int                phase_len;
      int                push_share;
      int                pick;
      logic [CMD_W-1:0]  cmd;
      logic [PRIO_W-1:0] prio;

      shadow           = new();
      reset            <= 1'b1;
      start            <= 1'b0;
      req_command      <= CMD_PUSH;
      req_task_id      <= '0;
      req_priority_req <= '0;
      idling_on        = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, bad priorities, unused code, both extreme levels
      issue(CMD_POP, 16'h1234, 4'd1);
      issue(CMD_PEEK, 16'h0000, 4'd8);
      issue(CMD_UNUSED, 16'hFFFF, 4'd4);
      issue(CMD_PUSH, 16'hFFFF, 4'd0);
      issue(CMD_POP, 16'h0000, 4'd9);
      issue(CMD_PEEK, 16'hFFFF, 4'd15);
      issue(CMD_PUSH, 16'h0000, 4'd1);
      issue(CMD_PUSH, 16'hFFFF, 4'd8);
      issue(CMD_PEEK, 16'h0000, 4'd1);
      issue(CMD_POP, 16'h0000, 4'd8);
      issue(CMD_POP, 16'h0000, 4'd1);
      issue(CMD_POP, 16'h0000, 4'd1);
      // Fill one level, then push once more into the full level
      for (int i = 0; i <= LEVEL_DEPTH_DEF; i++) issue(CMD_PUSH, TASK_W'(16'hA500 + i), 4'd5);
      issue(CMD_PEEK, 16'h0000, 4'd0);
      issue(CMD_POP, 16'h0000, 4'd5);
      drain_responses();

      // Random phases leaning toward filling, draining or a balanced mix
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len  = $urandom_range(40, 160);
         push_share = (phase_kind == 0) ? 80 : (phase_kind == 1) ? 15 : 50;
         for (int n = 0; n < phase_len && items_sent < RANDOM_ITEMS; n++) begin
            idling_on = !(items_sent >= 300 && items_sent < 550);
            pick = $urandom_range(0, 99);
            if (pick < push_share)  cmd = CMD_PUSH;
            else if (pick < 97)     cmd = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_POP;
            else                    cmd = CMD_UNUSED;
            // mostly legal levels, a few out of range
            if ($urandom_range(0, 99) < 8) begin
               pick = $urandom_range(0, 7);
               prio = (pick == 0) ? 4'd0 : PRIO_W'(LEVELS_DEF + pick);
            end else begin
               prio = PRIO_W'($urandom_range(1, LEVELS_DEF));
            end
            issue(cmd, TASK_W'($urandom_range(0, 65535)), prio);
            items_sent++;
         end
         if ($urandom_range(0, 3) == 0) drain_responses();
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
